// ===== sv/ptyld_pkg.sv =====
// Package for the pseudo-terminal line discipline engine.
// Holds ring geometry, request codes, control characters and the sequencer state type.
// No dependencies.
package ptyld_pkg;

  localparam int DEPTH = 4096;
  localparam int PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;

  localparam ptr_t LINE_MAX = ptr_t'(DEPTH - 1);

  localparam byte_t CH_BS    = 8'h08;
  localparam byte_t CH_DEL   = 8'h7f;
  localparam byte_t CH_LF    = 8'h0a;
  localparam byte_t CH_CR    = 8'h0d;
  localparam byte_t CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_KEY_IN      = 2'd0,
    OP_TERM_READ   = 2'd1,
    OP_SHELL_READ  = 2'd2,
    OP_SHELL_WRITE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ECHO,
    S_COPY,
    S_RESULT
  } state_t;

endpackage

// ===== sv/ptyld_ifs.sv =====
// Request and response channel interfaces for the line discipline engine.
// Depends on ptyld_pkg.
interface ptyld_req_if;
  import ptyld_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  byte_t      data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ptyld_rsp_if;
  import ptyld_pkg::*;
  logic  valid;
  logic  ready;
  byte_t read_data;
  logic  read_valid;
  logic  write_taken;
  logic  output_pending;
  logic  input_pending;
  logic  output_has_room;
  ptr_t  line_length;
  modport source (output valid, output read_data, output read_valid, output write_taken,
                  output output_pending, output input_pending, output output_has_room,
                  output line_length, input ready);
  modport sink   (input valid, input read_data, input read_valid, input write_taken,
                  input output_pending, input input_pending, input output_has_room,
                  input line_length, output ready);
endinterface

// ===== sv/pty_line_discipline_rings_top.sv =====
// Pseudo-terminal engine: input ring, output ring and line editor, each in a
// synchronous memory with registered read data; a sequencer reads, edits, writes back.
// An erase echoes as three output writes; a line commit copies one line byte per cycle
// into the input ring. One request at a time: a new one is taken only after the
// sequencer has registered the previous response.
// Synchronous reset clears pointers, line count and sequencer; memories are not cleared.
module pty_line_discipline_rings_top (
  input  logic            clk,
  input  logic            rst,
  ptyld_req_if.sink       req,
  ptyld_rsp_if.source     rsp
);
  import ptyld_pkg::*;

  byte_t in_mem   [DEPTH];
  byte_t out_mem  [DEPTH];
  byte_t line_mem [DEPTH];

  state_t state, state_next;
  op_t    cur_op;
  op_t    req_op;

  ptr_t in_wp, in_rp, out_wp, out_rp, line_count;
  ptr_t copy_idx, copy_len;
  logic [1:0] echo_idx;
  logic line_rvalid;

  byte_t in_rdata, out_rdata, line_rdata;
  byte_t res_data;
  logic  res_valid, res_taken;

  logic  rsp_valid, rsp_read_valid, rsp_write_taken;
  logic  rsp_out_pending, rsp_in_pending, rsp_out_room;
  byte_t rsp_data;
  ptr_t  rsp_line_len;

  logic  accept, is_erase, is_eol, line_full;
  logic  out_nonempty, out_room, in_nonempty;
  ptr_t  in_free, line_plus, copy_len_calc;
  logic  out_we, in_we, line_we, slot_free, copy_done;
  byte_t out_wdata;

  assign req_op       = op_t'(req.op);
  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign is_erase     = (req.data_byte == CH_BS) || (req.data_byte == CH_DEL);
  assign is_eol       = (req.data_byte == CH_LF) || (req.data_byte == CH_CR);
  assign line_full    = (line_count == LINE_MAX);
  assign out_nonempty = (out_wp != out_rp);
  assign in_nonempty  = (in_wp != in_rp);
  assign out_room     = ((out_rp - out_wp - ptr_t'(1)) != '0);
  assign in_free      = in_rp - in_wp - ptr_t'(1);
  assign line_plus    = line_count + ptr_t'(1);
  assign copy_len_calc = (line_plus <= in_free) ? line_plus : in_free;
  assign slot_free    = !rsp_valid || rsp.ready;
  assign copy_done    = (copy_idx == copy_len) && !line_rvalid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_op)
            OP_KEY_IN: begin
              if (is_erase) begin
                state_next = (line_count != '0) ? S_ECHO : S_RESULT;
              end else if (!line_full && is_eol && (copy_len_calc != '0)) begin
                state_next = S_COPY;
              end else begin
                state_next = S_RESULT;
              end
            end
            OP_TERM_READ:   state_next = out_nonempty ? S_READ : S_RESULT;
            OP_SHELL_READ:  state_next = in_nonempty ? S_READ : S_RESULT;
            OP_SHELL_WRITE: state_next = S_RESULT;
            default:        state_next = S_RESULT;
          endcase
        end
      end
      S_READ:   state_next = S_RESULT;
      S_ECHO:   state_next = (echo_idx == 2'd2) ? S_RESULT : S_ECHO;
      S_COPY:   state_next = copy_done ? S_RESULT : S_COPY;
      S_RESULT: state_next = slot_free ? S_IDLE : S_RESULT;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_we    = 1'b0;
    out_wdata = req.data_byte;
    in_we     = 1'b0;
    line_we   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_op == OP_KEY_IN && !is_erase && !line_full) begin
            line_we = 1'b1;
            out_we  = out_room;
          end else if (req_op == OP_SHELL_WRITE) begin
            out_we = out_room;
          end
        end
      end
      S_ECHO: begin
        out_we    = out_room;
        out_wdata = (echo_idx == 2'd1) ? CH_SPACE : CH_BS;
      end
      S_COPY:   in_we = line_rvalid;
      S_READ, S_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_rdata  <= out_mem[out_rp];
    in_rdata   <= in_mem[in_rp];
    line_rdata <= line_mem[copy_idx];
    if (out_we) begin
      out_mem[out_wp] <= out_wdata;
    end
    if (in_we) begin
      in_mem[in_wp] <= line_rdata;
    end
    if (line_we) begin
      line_mem[line_count] <= req.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_wp      <= '0;
      in_rp      <= '0;
      out_wp     <= '0;
      out_rp     <= '0;
      line_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_we) begin
        out_wp <= out_wp + ptr_t'(1);
      end
      if (in_we) begin
        in_wp <= in_wp + ptr_t'(1);
      end
      if (accept) begin
        cur_op      <= req_op;
        res_data    <= '0;
        res_valid   <= 1'b0;
        res_taken   <= 1'b0;
        echo_idx    <= '0;
        copy_idx    <= '0;
        copy_len    <= copy_len_calc;
        line_rvalid <= 1'b0;
        case (req_op)
          OP_KEY_IN: begin
            if (is_erase) begin
              if (line_count != '0) begin
                line_count <= line_count - ptr_t'(1);
                res_taken  <= 1'b1;
              end
            end else if (!line_full) begin
              res_taken  <= 1'b1;
              line_count <= is_eol ? '0 : line_plus;
            end
          end
          OP_TERM_READ: begin
            if (out_nonempty) begin
              out_rp <= out_rp + ptr_t'(1);
            end
          end
          OP_SHELL_READ: begin
            if (in_nonempty) begin
              in_rp <= in_rp + ptr_t'(1);
            end
          end
          OP_SHELL_WRITE: res_taken <= out_room;
          default: ;
        endcase
      end
      if (state == S_READ) begin
        res_data  <= (cur_op == OP_TERM_READ) ? out_rdata : in_rdata;
        res_valid <= 1'b1;
      end
      if (state == S_ECHO) begin
        echo_idx <= echo_idx + 2'd1;
      end
      if (state == S_COPY) begin
        if (copy_idx != copy_len) begin
          copy_idx    <= copy_idx + ptr_t'(1);
          line_rvalid <= 1'b1;
        end else begin
          line_rvalid <= 1'b0;
        end
      end
      if (state == S_RESULT && slot_free) begin
        rsp_valid       <= 1'b1;
        rsp_data        <= res_data;
        rsp_read_valid  <= res_valid;
        rsp_write_taken <= res_taken;
        rsp_out_pending <= out_nonempty;
        rsp_in_pending  <= in_nonempty;
        rsp_out_room    <= out_room;
        rsp_line_len    <= line_count;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.read_data       = rsp_data;
  assign rsp.read_valid      = rsp_read_valid;
  assign rsp.write_taken     = rsp_write_taken;
  assign rsp.output_pending  = rsp_out_pending;
  assign rsp.input_pending   = rsp_in_pending;
  assign rsp.output_has_room = rsp_out_room;
  assign rsp.line_length     = rsp_line_len;

  assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && line_rvalid) |-> (in_free != '0))
    else $error("line copy wrote into a full input ring");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (line_count == '0))
    else $error("line not cleared during commit");

  assert property (@(posedge clk) disable iff (rst)
    (accept && req_op == OP_KEY_IN && is_eol && !line_full) |=> (line_count == '0))
    else $error("end of line did not clear the line");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_read_valid) |-> !rsp_write_taken)
    else $error("response marks both a read and a write");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for pty_line_discipline_rings_top: keyboard, terminal and shell requests
// checked against an in-bench predictor of the two rings and the line editor.
// Depends on ptyld_pkg, ptyld_req_if and ptyld_rsp_if.
module testbench;
  import ptyld_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    byte_t read_data;
    logic  read_valid;
    logic  write_taken;
    logic  output_pending;
    logic  input_pending;
    logic  output_has_room;
    ptr_t  line_length;
  } pty_result_t;

  logic clk = 1'b0;
  logic rst;
  logic quiet;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   stall_left = 0;

  byte_t in_ring    [DEPTH];
  byte_t out_ring   [DEPTH];
  byte_t edit_store [DEPTH];
  ptr_t  in_wp, in_rp, out_wp, out_rp, edit_count;

  pty_result_t pending_results[$];

  ptyld_req_if req ();
  ptyld_rsp_if rsp ();

  pty_line_discipline_rings_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic out_put(byte_t b);
    if (ptr_t'(out_wp - out_rp) == LINE_MAX) return 1'b0;
    out_ring[out_wp] = b;
    out_wp = out_wp + ptr_t'(1);
    return 1'b1;
  endfunction

  function automatic logic in_put(byte_t b);
    if (ptr_t'(in_wp - in_rp) == LINE_MAX) return 1'b0;
    in_ring[in_wp] = b;
    in_wp = in_wp + ptr_t'(1);
    return 1'b1;
  endfunction

  function automatic logic key_in(byte_t ch);
    int n;
    if (ch == CH_BS || ch == CH_DEL) begin
      if (edit_count == '0) return 1'b0;
      edit_count = edit_count - ptr_t'(1);
      void'(out_put(CH_BS));
      void'(out_put(CH_SPACE));
      void'(out_put(CH_BS));
      return 1'b1;
    end
    if (edit_count >= LINE_MAX) return 1'b0;
    edit_store[edit_count] = ch;
    edit_count = edit_count + ptr_t'(1);
    void'(out_put(ch));
    if (ch == CH_LF || ch == CH_CR) begin
      for (n = 0; n < int'(edit_count); n++) begin
        if (!in_put(edit_store[ptr_t'(n)])) break;
      end
      edit_count = '0;
    end
    return 1'b1;
  endfunction

  function automatic pty_result_t apply_request(op_t op, byte_t b);
    pty_result_t r;
    r = '0;
    case (op)
      OP_KEY_IN: begin
        r.write_taken = key_in(b);
      end
      OP_TERM_READ: begin
        if (out_wp != out_rp) begin
          r.read_data  = out_ring[out_rp];
          r.read_valid = 1'b1;
          out_rp = out_rp + ptr_t'(1);
        end
      end
      OP_SHELL_READ: begin
        if (in_wp != in_rp) begin
          r.read_data  = in_ring[in_rp];
          r.read_valid = 1'b1;
          in_rp = in_rp + ptr_t'(1);
        end
      end
      OP_SHELL_WRITE: begin
        r.write_taken = out_put(b);
      end
      default: ;
    endcase
    r.output_pending  = (out_wp != out_rp);
    r.input_pending   = (in_wp != in_rp);
    r.output_has_room = (ptr_t'(out_wp - out_rp) != LINE_MAX);
    r.line_length     = edit_count;
    return r;
  endfunction

  function automatic string fmt_result(pty_result_t r);
    return $sformatf("data=%0h valid=%0b taken=%0b out_pend=%0b in_pend=%0b room=%0b len=%0d",
                     r.read_data, r.read_valid, r.write_taken, r.output_pending,
                     r.input_pending, r.output_has_room, r.line_length);
  endfunction

  task automatic send_request(op_t op, byte_t b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.data_byte <= b;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(apply_request(op, b));
  endtask

  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic drain_terminal();
    while (out_wp != out_rp) send_request(OP_TERM_READ, byte_t'($urandom_range(0, 255)));
    send_request(OP_TERM_READ, byte_t'($urandom_range(0, 255)));
  endtask

  task automatic drain_shell();
    while (in_wp != in_rp) send_request(OP_SHELL_READ, byte_t'($urandom_range(0, 255)));
    send_request(OP_SHELL_READ, byte_t'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_cases();
    send_request(OP_TERM_READ, 8'hff);
    send_request(OP_SHELL_READ, 8'h00);
    send_request(OP_KEY_IN, CH_BS);
    send_request(OP_KEY_IN, CH_DEL);
    send_request(OP_KEY_IN, 8'h00);
    send_request(OP_KEY_IN, 8'hff);
    send_request(OP_KEY_IN, CH_BS);
    send_request(OP_KEY_IN, 8'h41);
    send_request(OP_KEY_IN, CH_DEL);
    send_request(OP_KEY_IN, 8'h41);
    send_request(OP_KEY_IN, CH_CR);
    send_request(OP_KEY_IN, 8'h55);
    send_request(OP_KEY_IN, 8'haa);
    send_request(OP_KEY_IN, CH_LF);
    send_request(OP_KEY_IN, CH_LF);
    send_request(OP_SHELL_WRITE, 8'hff);
    send_request(OP_SHELL_WRITE, 8'h00);
    send_request(OP_SHELL_WRITE, CH_SPACE);
    drain_shell();
    drain_terminal();
  endtask

  task automatic test_random_traffic(int count);
    int   i;
    int   pick;
    int   kind;
    byte_t b;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      if (i == count - 200) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      b = byte_t'($urandom_range(0, 255));
      if (pick < 32) begin
        kind = $urandom_range(0, 19);
        if (kind == 0)      b = CH_BS;
        else if (kind == 1) b = CH_DEL;
        else if (kind == 2) b = CH_LF;
        else if (kind == 3) b = CH_CR;
        send_request(OP_KEY_IN, b);
      end else if (pick < 40) begin
        send_request(OP_SHELL_WRITE, b);
      end else if (pick < 80) begin
        send_request(OP_TERM_READ, b);
      end else begin
        send_request(OP_SHELL_READ, b);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      rsp.ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pty_result_t got;
    pty_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.read_data, rsp.read_valid, rsp.write_taken, rsp.output_pending,
              rsp.input_pending, rsp.output_has_room, rsp.line_length};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.read_valid !== want.read_valid ||
            got.write_taken !== want.write_taken ||
            got.output_pending !== want.output_pending ||
            got.input_pending !== want.input_pending ||
            got.output_has_room !== want.output_has_room ||
            got.line_length !== want.line_length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response mismatch\n  expected %s\n  actual   %s",
                     fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    quiet          = 1'b0;
    req.valid      = 1'b0;
    req.op         = OP_KEY_IN;
    req.data_byte  = '0;
    in_wp = '0; in_rp = '0; out_wp = '0; out_rp = '0; edit_count = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(1460);

    wait_for_results();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ptyld_pkg.sv
sv/ptyld_ifs.sv
sv/pty_line_discipline_rings_top.sv
tb/sv/testbench.sv
